[hdl/s64tr_pkg.sv]
// Shared types, constants and helper functions of the 64-column text renderer.
package s64tr_pkg;

    // Default text geometry.
    localparam int TEXT_COLUMNS_DEF = 64;
    localparam int TEXT_ROWS_DEF    = 24;

    // Frame store and glyph store geometry.
    localparam int FRAME_BYTES = 6912;
    localparam int GLYPH_BYTES = 2048;
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);
    localparam int GLYPH_AW    = $clog2(GLYPH_BYTES);
    localparam logic [FRAME_AW-1:0] ATTR_BASE = FRAME_AW'(6144);
    localparam logic [FRAME_AW-1:0] FRAME_LAST = FRAME_AW'(FRAME_BYTES - 1);

    // Stream word widths.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // Attribute bits.
    localparam logic [7:0] ATTR_FLASH = 8'h80;

    // Spectrum colour numbering for each curses colour.
    localparam logic [2:0] COLOUR_REMAP [8] = '{
        3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd7
    };

    // Operation codes carried in tuser.
    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_MOVE  = 2'd1,
        FUNC_FLASH = 2'd2,
        FUNC_FONT  = 2'd3
    } t_func;

    // Input word layout, most significant member first.
    typedef struct packed {
        logic        pad;
        logic [7:0]  font_byte;
        logic [10:0] font_index;
        logic [6:0]  column;
        logic [4:0]  row;
        logic [5:0]  color_pair;
        logic        bright;
        logic        reverse_video;
        logic [7:0]  char_code;
    } t_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic font_wr;
        logic move;
        logic put_rd;
        logic put_wr;
        logic attr_wr;
        logic flash_rd;
        logic flash_wr;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic clear_done;
        logic row_last;
    } t_stat;

    // Attribute byte for a colour pair and bright flag.
    function automatic logic [7:0] make_attr(input logic [5:0] pair, input logic bright);
        logic [2:0] fg;
        logic [2:0] bg;
        fg = pair[2:0];
        bg = pair[5:3];
        if (pair == 6'd0) begin
            fg = 3'd7;
            bg = 3'd0;
        end else if (pair == 6'd7) begin
            fg = 3'd0;
            bg = 3'd0;
        end
        return {1'b0, bright, COLOUR_REMAP[bg], COLOUR_REMAP[fg]};
    endfunction

endpackage

[hdl/spectrum_64col_text_renderer.sv]
// Top level of the 64-column text renderer: controller, datapath and stream ports.
//
// Each input word carries one operation in tuser (put char, move cursor, set flash,
// load glyph byte); every frame store write it causes is sent out as one address/data
// word, tlast marking the final write of the operation. The frame store is used
// read-modify-write, one glyph row a cycle while the output is not stalled: a put
// char is a read, eight row writes and the attribute write, and a flash is a read
// and a write of the attribute byte. After reset the frame store is cleared one byte
// a cycle, all 6912 bytes, during which no input word is accepted.
module spectrum_64col_text_renderer
    import s64tr_pkg::*;
#(
    parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
    parameter int TEXT_ROWS    = TEXT_ROWS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // char_code[7:0], reverse_video[8], bright[9], color_pair[15:10], row[20:16],
    // column[27:21], font_index[38:28], font_byte[46:39], zero[47]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // mem_addr[12:0], mem_data[20:13], zero[23:21]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    t_cmd  cmd;
    t_stat stat;

    s64tr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (t_func'(s_axis_tuser)),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    s64tr_dp #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (t_item'(s_axis_tdata)),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

[hdl/s64tr_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module s64tr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; the read data holds when not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/s64tr_ctrl.sv]
// Controller state machine that sequences the clearing pass and each operation.
module s64tr_ctrl
    import s64tr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_func i_func,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_FONT   = 9'b000000100,
        ST_MOVE   = 9'b000001000,
        ST_PREAD  = 9'b000010000,
        ST_PWRITE = 9'b000100000,
        ST_PATTR  = 9'b001000000,
        ST_FREAD  = 9'b010000000,
        ST_FWRITE = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_func)
                        FUNC_PUT:   n_state = ST_PREAD;
                        FUNC_MOVE:  n_state = ST_MOVE;
                        FUNC_FLASH: n_state = ST_FREAD;
                        FUNC_FONT:  n_state = ST_FONT;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FONT: begin
                o_cmd.font_wr = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_PREAD: begin
                o_cmd.put_rd = 1'b1;
                n_state      = ST_PWRITE;
            end
            ST_PWRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.put_wr = 1'b1;
                    if (i_stat.row_last) begin
                        n_state = ST_PATTR;
                    end
                end
            end
            ST_PATTR: begin
                if (i_stat.out_free) begin
                    o_cmd.attr_wr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_FREAD: begin
                o_cmd.flash_rd = 1'b1;
                n_state        = ST_FWRITE;
            end
            ST_FWRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.flash_wr = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

`ifndef NO_ASSERTIONS
    // The attribute write of a put char only ever follows its eighth bitmap write.
    a_attr_after_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PATTR && $past(r_state) != ST_PATTR)
            |-> ($past(r_state) == ST_PWRITE && $past(i_stat.row_last)))
        else $error("attribute state entered before all glyph rows were written");

    // No word is taken before the clearing pass has finished.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_cmd.capture)
        else $error("word captured during the clearing pass");
`endif

endmodule

[hdl/s64tr_dp.sv]
// Datapath: item registers, cursor, frame and glyph stores, and the result register.
module s64tr_dp
    import s64tr_pkg::*;
#(
    parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
    parameter int TEXT_ROWS    = TEXT_ROWS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  t_item                  i_item,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic                   o_out_last
);

    // Captured item.
    logic [7:0]  r_code;
    logic        r_rev;
    logic        r_bright;
    logic [5:0]  r_pair;
    logic [4:0]  r_row_in;
    logic [6:0]  r_col_in;
    logic [10:0] r_fidx;
    logic [7:0]  r_fbyte;

    // Cursor, glyph row index and clearing address.
    logic [5:0]          r_cur_col;
    logic [4:0]          r_cur_row;
    logic [5:0]          n_cur_col;
    logic [4:0]          n_cur_row;
    logic [2:0]          r_row_idx;
    logic [FRAME_AW-1:0] r_clr_addr;

    // Result register.
    logic                r_out_valid;
    logic [FRAME_AW-1:0] r_out_addr;
    logic [7:0]          r_out_data;
    logic                r_out_last;

    logic                w_out_free;
    logic [4:0]          w_half;
    logic [FRAME_AW-1:0] w_attr_addr;
    logic [2:0]          w_rd_idx;
    logic [7:0]          w_glyph;
    logic [7:0]          w_merged;

    logic                fr_we;
    logic [FRAME_AW-1:0] fr_waddr;
    logic [7:0]          fr_wdata;
    logic                fr_re;
    logic [FRAME_AW-1:0] fr_raddr;
    logic [7:0]          fr_rdata;
    logic                gl_re;
    logic [7:0]          gl_rdata;

    // Interleaved bitmap address of glyph row idx in the cursor cell.
    function automatic logic [FRAME_AW-1:0] bmp_addr(input logic [4:0] row,
                                                     input logic [4:0] half,
                                                     input logic [2:0] idx);
        return {row[4:3], idx, row[2:0], half};
    endfunction

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_half      = r_cur_col[5:1];
    assign w_attr_addr = ATTR_BASE + FRAME_AW'({r_cur_row, w_half});
    assign w_rd_idx    = i_cmd.put_wr ? (r_row_idx + 3'd1) : r_row_idx;

    // Glyph nibble merged into the display byte by column parity.
    assign w_glyph  = gl_rdata ^ {8{r_rev}};
    assign w_merged = r_cur_col[0] ? {fr_rdata[7:4], w_glyph[7:4]}
                                   : {w_glyph[7:4], fr_rdata[3:0]};

    // Frame store port selection.
    always_comb begin
        fr_we    = i_cmd.clear_wr | i_cmd.put_wr | i_cmd.attr_wr | i_cmd.flash_wr;
        fr_waddr = w_attr_addr;
        fr_wdata = fr_rdata | ATTR_FLASH;
        priority if (i_cmd.clear_wr) begin
            fr_waddr = r_clr_addr;
            fr_wdata = 8'h00;
        end else if (i_cmd.put_wr) begin
            fr_waddr = bmp_addr(r_cur_row, w_half, r_row_idx);
            fr_wdata = w_merged;
        end else if (i_cmd.attr_wr) begin
            fr_wdata = make_attr(r_pair, r_bright);
        end else begin
            fr_wdata = fr_rdata | ATTR_FLASH;
        end
        gl_re    = i_cmd.put_rd | (i_cmd.put_wr & (r_row_idx != 3'd7));
        fr_re    = gl_re | i_cmd.flash_rd;
        fr_raddr = i_cmd.flash_rd ? w_attr_addr : bmp_addr(r_cur_row, w_half, w_rd_idx);
    end

    s64tr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_re    (fr_re),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    s64tr_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_BYTES)
    ) u_glyph (
        .i_clk   (i_clk),
        .i_we    (i_cmd.font_wr),
        .i_waddr (r_fidx),
        .i_wdata (r_fbyte),
        .i_re    (gl_re),
        .i_raddr ({r_code, w_rd_idx}),
        .o_rdata (gl_rdata)
    );

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code   <= i_item.char_code;
            r_rev    <= i_item.reverse_video;
            r_bright <= i_item.bright;
            r_pair   <= i_item.color_pair;
            r_row_in <= i_item.row;
            r_col_in <= i_item.column;
            r_fidx   <= i_item.font_index;
            r_fbyte  <= i_item.font_byte;
        end
    end

    // Cursor update on a move and advance with wrap after a put char.
    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        if (i_cmd.move) begin
            if ({1'b0, r_row_in} < 6'(TEXT_ROWS)) begin
                n_cur_row = r_row_in;
            end
            if (r_col_in < 7'(TEXT_COLUMNS)) begin
                n_cur_col = r_col_in[5:0];
            end
        end else if (i_cmd.attr_wr) begin
            if (r_cur_col == 6'(TEXT_COLUMNS - 1)) begin
                n_cur_col = 6'd0;
                n_cur_row = (r_cur_row == 5'(TEXT_ROWS - 1)) ? 5'd0 : r_cur_row + 5'd1;
            end else begin
                n_cur_col = r_cur_col + 6'd1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_row_idx  <= '0;
            r_clr_addr <= '0;
        end else begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            if (i_cmd.capture) begin
                r_row_idx <= '0;
            end else if (i_cmd.put_wr) begin
                r_row_idx <= r_row_idx + 3'd1;
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + FRAME_AW'(1);
            end
        end
    end

    // Result register: loaded with every reported store write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put_wr || i_cmd.attr_wr || i_cmd.flash_wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_wr || i_cmd.attr_wr || i_cmd.flash_wr) begin
            r_out_addr <= fr_waddr;
            r_out_data <= fr_wdata;
            r_out_last <= i_cmd.attr_wr | i_cmd.flash_wr;
        end
    end

    assign o_stat.out_free   = w_out_free;
    assign o_stat.clear_done = (r_clr_addr == FRAME_LAST);
    assign o_stat.row_last   = (r_row_idx == 3'd7);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {3'b000, r_out_data, r_out_addr};
    assign o_out_last  = r_out_last;

`ifndef NO_ASSERTIONS
    // A reported write never overwrites a word still waiting downstream.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put_wr || i_cmd.attr_wr || i_cmd.flash_wr) |-> w_out_free)
        else $error("result register overwritten while stalled");

    // Bitmap writes stay below the attribute area.
    a_bitmap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put_wr |-> (fr_waddr < ATTR_BASE))
        else $error("bitmap write into the attribute area");

    // The cursor always addresses a cell of the text screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cur_col} < 7'(TEXT_COLUMNS)) && ({1'b0, r_cur_row} < 6'(TEXT_ROWS)))
        else $error("cursor outside the text screen");
`endif

endmodule
